// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/fts_pkg.sv =====
package fts_pkg;

    // Field widths.
    localparam int STAMP_W = 48;
    localparam int DELTA_W = 17;
    localparam int EMA_W   = 25;
    localparam int FPS_W   = 28;
    localparam int TICK_W  = 40;

    // Stream widths: the output fields packed from delta upward, padded to bytes.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_FIELD_W = DELTA_W + EMA_W + DELTA_W + FPS_W + TICK_W + STAMP_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Timing constants in microseconds.
    localparam logic [DELTA_W-1:0] MAX_DELTA    = DELTA_W'(100000);
    localparam logic [DELTA_W-1:0] PRESET_DELTA = DELTA_W'(16666);
    localparam logic [FPS_W-1:0]   FPS_NUM_Q8   = FPS_W'(256000000);

    // Exponential average: numerator 4*ema + 256*delta + 2 fits 27 bits, divided by 5.
    localparam int EMA_NUM_W = 27;
    localparam int EMA_REM_W = 3;
    localparam logic [EMA_REM_W:0] EMA_DIVISOR = 4'd5;

    // Sequencer counter covers the serial subtract and the serial divides.
    localparam int CNT_W     = 6;
    localparam int DIV_STEPS = FPS_W;

    localparam int DEFAULT_WINDOW_DEPTH = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ===== sv/frame_time_smoother_top.sv =====
// Sequence: an accepted tick runs the bit-serial timestamp subtract, a prepare step, the
// bit-serial EMA and FPS divides and a done state while running; a paused tick goes straight
// to done. A new tick is accepted only in idle, after the previous tick reaches done.
// The output register lets the next tick be accepted while a result waits to be taken.
// Reset (synchronous, active low) clears control and timing state; the delta ring reads as
// 16666 us until the write pointer first wraps, so no clearing pass is needed.
module frame_time_smoother_top #(
    parameter int WINDOW_DEPTH = fts_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration: paused_mode.
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    // Input ticks.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata fields from bit 0: now_us[47:0].
    input  logic [fts_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // Results.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata fields from bit 0: delta_us[16:0], smooth_delta_q8[41:17], window_avg_us[58:42],
    // fps_q8[86:59], frames_seen[126:87], elapsed_us[174:127], zero pad [175].
    output logic [fts_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

`include "assert_macros.svh"

    // The window mean is a shift, so the depth must be a power of two; the block does not check it.
    localparam int POS_W   = $clog2(WINDOW_DEPTH);
    localparam int TOTAL_W = fts_pkg::DELTA_W + POS_W;
    localparam logic [TOTAL_W-1:0] TotalReset =
        TOTAL_W'(WINDOW_DEPTH * int'(fts_pkg::PRESET_DELTA));
    localparam logic [POS_W-1:0] LastPos = POS_W'(WINDOW_DEPTH - 1);
    // Clamp limit widened so the serial compare can index it by the bit counter.
    localparam logic [2**fts_pkg::CNT_W-1:0] MaxDeltaBits =
        (2**fts_pkg::CNT_W)'(fts_pkg::MAX_DELTA);
    localparam int PAD_W = fts_pkg::OUT_TDATA_W - fts_pkg::OUT_FIELD_W;

    // Control state.
    fts_pkg::t_state r_state, n_state;
    logic [fts_pkg::CNT_W-1:0] r_cnt;
    logic r_paused;
    logic r_skip;
    logic r_out_valid;

    // Timing state.
    logic [fts_pkg::STAMP_W-1:0] r_last;
    logic [fts_pkg::EMA_W-1:0]   r_ema;
    logic [TOTAL_W-1:0]          r_total;
    logic [POS_W-1:0]            r_pos;
    logic                        r_wrapped;
    logic [fts_pkg::TICK_W-1:0]  r_ticks;

    // Work registers.
    logic [fts_pkg::STAMP_W-1:0]   r_diff;
    logic                          r_borrow;
    logic                          r_gt;
    logic [fts_pkg::DELTA_W-1:0]   r_delta;
    logic [fts_pkg::DELTA_W-1:0]   r_avg;
    logic [fts_pkg::EMA_NUM_W-1:0] r_ema_num;
    logic [fts_pkg::EMA_REM_W-1:0] r_ema_rem;
    logic [fts_pkg::FPS_W-1:0]     r_fps_num;
    logic [fts_pkg::DELTA_W-1:0]   r_fps_rem;
    logic [fts_pkg::OUT_TDATA_W-1:0] r_out_data;

    // Sequencer controls.
    logic w_accept;
    logic w_sub_step;
    logic w_prep;
    logic w_div_step;
    logic w_div_last;
    logic w_load_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fts_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = r_paused ? fts_pkg::ST_DONE : fts_pkg::ST_SUB;
                end
            end
            fts_pkg::ST_SUB: begin
                if (r_cnt == fts_pkg::CNT_W'(fts_pkg::STAMP_W - 1)) begin
                    n_state = fts_pkg::ST_PREP;
                end
            end
            fts_pkg::ST_PREP: begin
                n_state = fts_pkg::ST_DIV;
            end
            fts_pkg::ST_DIV: begin
                if (r_cnt == fts_pkg::CNT_W'(fts_pkg::DIV_STEPS - 1)) begin
                    n_state = fts_pkg::ST_DONE;
                end
            end
            fts_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = fts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fts_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_sub_step      = 1'b0;
        w_prep          = 1'b0;
        w_div_step      = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            fts_pkg::ST_IDLE: o_s_axis_tready = 1'b1;
            fts_pkg::ST_SUB:  w_sub_step = 1'b1;
            fts_pkg::ST_PREP: w_prep = 1'b1;
            fts_pkg::ST_DIV:  w_div_step = 1'b1;
            fts_pkg::ST_DONE: w_load_out = !r_out_valid || i_m_axis_tready;
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    assign w_accept   = o_s_axis_tready && i_s_axis_tvalid;
    assign w_div_last = w_div_step && (r_cnt == fts_pkg::CNT_W'(fts_pkg::DIV_STEPS - 1));

    // Serial subtract, one bit per cycle from the LSB, with a running clamp compare.
    logic w_a, w_b, w_d, w_m;
    always_comb begin
        w_a = r_diff[0];
        w_b = r_last[0];
        w_d = w_a ^ w_b ^ r_borrow;
        w_m = MaxDeltaBits[r_cnt];
    end

    // Ring memory holding the last deltas.
    logic [fts_pkg::DELTA_W-1:0] w_rd_data;
    logic [fts_pkg::DELTA_W-1:0] w_old;
    logic [fts_pkg::DELTA_W-1:0] w_delta;
    logic [TOTAL_W-1:0]          w_total;

    fts_ram #(
        .WIDTH (fts_pkg::DELTA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_prep),
        .i_waddr (r_pos),
        .i_wdata (w_delta),
        .i_re    (w_accept),
        .i_raddr (r_pos),
        .o_rdata (w_rd_data)
    );

    // Clamped delta, ring sum update and EMA numerator.
    always_comb begin
        w_delta = r_gt ? fts_pkg::MAX_DELTA : r_diff[fts_pkg::DELTA_W-1:0];
        w_old   = r_wrapped ? w_rd_data : fts_pkg::PRESET_DELTA;
        w_total = r_total - TOTAL_W'(w_old) + TOTAL_W'(w_delta);
    end

    logic [fts_pkg::EMA_NUM_W-1:0] w_ema_init;
    assign w_ema_init = {r_ema, 2'b00} + {2'b00, w_delta, 8'd0}
                        + fts_pkg::EMA_NUM_W'(2);

    // Divide steps: by five for the EMA, by the window mean for the frame rate.
    logic [fts_pkg::EMA_REM_W:0] w_ema_part;
    logic                        w_ema_ge;
    logic [fts_pkg::DELTA_W:0]   w_fps_part;
    logic                        w_fps_ge;
    logic [fts_pkg::DELTA_W:0]   w_fps_diff;
    always_comb begin
        w_ema_part = {r_ema_rem, r_ema_num[fts_pkg::EMA_NUM_W-1]};
        w_ema_ge   = w_ema_part >= fts_pkg::EMA_DIVISOR;
        w_fps_part = {r_fps_rem, r_fps_num[fts_pkg::FPS_W-1]};
        w_fps_ge   = w_fps_part >= {1'b0, r_avg};
        w_fps_diff = w_fps_part - {1'b0, r_avg};
    end

    // Result assembly.
    logic [fts_pkg::OUT_TDATA_W-1:0] w_result;
    logic [fts_pkg::FPS_W-1:0]       w_fps;
    always_comb begin
        w_fps = (r_avg == '0) ? '0 : r_fps_num;
        if (r_skip) begin
            w_result = {{PAD_W{1'b0}}, r_last, r_ticks,
                        {(fts_pkg::DELTA_W + fts_pkg::EMA_W + fts_pkg::DELTA_W
                          + fts_pkg::FPS_W){1'b0}}};
        end else begin
            w_result = {{PAD_W{1'b0}}, r_last, r_ticks, w_fps, r_avg, r_ema, r_delta};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fts_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_paused    <= 1'b0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_ema       <= '0;
            r_total     <= TotalReset;
            r_pos       <= '0;
            r_wrapped   <= 1'b0;
            r_ticks     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_paused <= i_cfg_wdata;
            end
            if (w_accept || w_prep || w_div_last) begin
                r_cnt <= '0;
            end else if (w_sub_step || w_div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_accept) begin
                r_skip <= r_paused;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            // The new timestamp rotates into the last-stamp register during the subtract.
            if (w_sub_step) begin
                r_last <= {w_a, r_last[fts_pkg::STAMP_W-1:1]};
            end
            if (w_prep) begin
                r_total <= w_total;
                r_pos   <= (r_pos == LastPos) ? '0 : r_pos + 1'b1;
                r_ticks <= r_ticks + 1'b1;
                if (r_pos == LastPos) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (w_div_last) begin
                r_ema <= r_ema_num[fts_pkg::EMA_W-1:0] +
                         fts_pkg::EMA_W'(w_ema_ge && (r_cnt < fts_pkg::CNT_W'(fts_pkg::EMA_NUM_W)));
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_diff   <= i_s_axis_tdata[fts_pkg::STAMP_W-1:0];
            r_borrow <= 1'b0;
            r_gt     <= 1'b0;
        end else if (w_sub_step) begin
            r_diff   <= {w_d, r_diff[fts_pkg::STAMP_W-1:1]};
            r_borrow <= (!w_a && w_b) || (!(w_a ^ w_b) && r_borrow);
            r_gt     <= (w_d && !w_m) || (!(w_d ^ w_m) && r_gt);
        end
        if (w_prep) begin
            r_delta   <= w_delta;
            r_avg     <= w_total[TOTAL_W-1 -: fts_pkg::DELTA_W];
            r_ema_num <= w_ema_init;
            r_ema_rem <= '0;
            r_fps_num <= fts_pkg::FPS_NUM_Q8;
            r_fps_rem <= '0;
        end else if (w_div_step) begin
            if (r_cnt < fts_pkg::CNT_W'(fts_pkg::EMA_NUM_W)) begin
                r_ema_num <= {r_ema_num[fts_pkg::EMA_NUM_W-2:0], w_ema_ge};
                r_ema_rem <= w_ema_ge ? fts_pkg::EMA_REM_W'(w_ema_part - fts_pkg::EMA_DIVISOR)
                                      : w_ema_part[fts_pkg::EMA_REM_W-1:0];
            end
            r_fps_num <= {r_fps_num[fts_pkg::FPS_W-2:0], w_fps_ge};
            r_fps_rem <= w_fps_ge ? w_fps_diff[fts_pkg::DELTA_W-1:0]
                                  : w_fps_part[fts_pkg::DELTA_W-1:0];
        end
        if (w_load_out) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A tick either starts the subtract or, when paused, goes straight to the result.
    `ASSERT_NEXT(a_accept_next, i_clk, i_rst_n, w_accept,
        r_state == fts_pkg::ST_SUB || r_state == fts_pkg::ST_DONE)
    // The delivered delta never exceeds the clamp.
    `ASSERT_IMPLIES(a_delta_clamped, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tdata[fts_pkg::DELTA_W-1:0] <= fts_pkg::MAX_DELTA)
    // A zero window mean reports a zero frame rate.
    `ASSERT_IMPLIES(a_fps_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata[58:42] == '0),
        o_m_axis_tdata[86:59] == '0)

endmodule

// ===== sv/fts_ram.sv =====
module fts_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/frame_time_checker.sv =====
`timescale 1ns / 1ps

// Watches the tick and result streams, predicts the timing statistics for
// every accepted tick and compares each accepted result with the oldest one.
module frame_time_checker #(
    parameter int WINDOW_DEPTH = fts_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // tdata fields from bit 0: now_us.
    input  logic [fts_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // tdata fields from bit 0: delta_us, smooth_delta_q8, window_avg_us, fps_q8,
    // frames_seen, elapsed_us, zero pad.
    input  logic [fts_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int POS_W = $clog2(WINDOW_DEPTH);

    typedef struct packed {
        logic [fts_pkg::DELTA_W-1:0] delta;
        logic [fts_pkg::EMA_W-1:0]   ema;
        logic [fts_pkg::DELTA_W-1:0] window_avg;
        logic [fts_pkg::FPS_W-1:0]   fps;
        logic [fts_pkg::TICK_W-1:0]  frames;
        logic [fts_pkg::STAMP_W-1:0] elapsed;
    } t_frame_stats;

    // Timing state of the predictor.
    logic [fts_pkg::STAMP_W-1:0] prev_stamp;
    logic [fts_pkg::DELTA_W-1:0] delta_hist [WINDOW_DEPTH];
    logic [POS_W-1:0]            hist_pos;
    logic [31:0]                 hist_sum;
    logic [fts_pkg::EMA_W-1:0]   ema_q8;
    logic [fts_pkg::TICK_W-1:0]  frame_count;
    logic                        paused;

    t_frame_stats predicted_stats [$];
    int           fail_total = 0;

    // Applies one tick to the timing state and returns the statistics it reports.
    function automatic t_frame_stats advance_timing(input logic [fts_pkg::STAMP_W-1:0] now);
        t_frame_stats                r;
        logic [fts_pkg::STAMP_W-1:0] gap;
        logic [fts_pkg::DELTA_W-1:0] delta;
        logic [63:0]                 num;
        logic [31:0]                 avg;
        r = '0;
        if (paused) begin
            // A paused tick only reports the frozen count and timestamp.
            r.frames  = frame_count;
            r.elapsed = prev_stamp;
            return r;
        end
        gap = now - prev_stamp;
        delta = (gap > fts_pkg::STAMP_W'(fts_pkg::MAX_DELTA)) ? fts_pkg::MAX_DELTA
                                                               : gap[fts_pkg::DELTA_W-1:0];
        prev_stamp = now;

        // Exponential average with factor 0.2, rounded half up.
        num = 64'(ema_q8) * 4 + 64'(delta) * 256 + 64'd2;
        ema_q8 = fts_pkg::EMA_W'(num / 5);

        // Sliding window of the last deltas with its running sum.
        hist_sum = hist_sum - 32'(delta_hist[hist_pos]) + 32'(delta);
        delta_hist[hist_pos] = delta;
        hist_pos = (hist_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : hist_pos + 1'b1;
        frame_count = frame_count + 1'b1;

        avg = hist_sum / WINDOW_DEPTH;
        r.delta      = delta;
        r.ema        = ema_q8;
        r.window_avg = avg[fts_pkg::DELTA_W-1:0];
        r.fps        = (avg == 0) ? '0 : fts_pkg::FPS_W'(32'(fts_pkg::FPS_NUM_Q8) / avg);
        r.frames     = frame_count;
        r.elapsed    = prev_stamp;
        return r;
    endfunction

    task automatic check_field(input string label, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_total++;
        end
    endtask

    // Results are matched before new ticks are predicted, since a result can
    // never belong to a tick taken at the same edge.
    always @(posedge i_clk) begin
        t_frame_stats want;
        t_frame_stats got;
        if (!i_rst_n) begin
            prev_stamp  = '0;
            hist_pos    = '0;
            hist_sum    = 32'(WINDOW_DEPTH) * 32'(fts_pkg::PRESET_DELTA);
            ema_q8      = '0;
            frame_count = '0;
            paused      = 1'b0;
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                delta_hist[k] = fts_pkg::PRESET_DELTA;
            end
            predicted_stats.delete();
        end else begin
            if (i_cfg_we) begin
                paused = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.delta      = i_m_tdata[16:0];
                got.ema        = i_m_tdata[41:17];
                got.window_avg = i_m_tdata[58:42];
                got.fps        = i_m_tdata[86:59];
                got.frames     = i_m_tdata[126:87];
                got.elapsed    = i_m_tdata[174:127];
                if (predicted_stats.size() == 0) begin
                    $display("%0t: result with no tick waiting, actual tdata %h",
                             $time, i_m_tdata);
                    fail_total++;
                end else begin
                    want = predicted_stats.pop_front();
                    check_field("delta_us", want.delta, got.delta);
                    check_field("smooth_delta_q8", want.ema, got.ema);
                    check_field("window_avg_us", want.window_avg, got.window_avg);
                    check_field("fps_q8", want.fps, got.fps);
                    check_field("frames_seen", want.frames, got.frames);
                    check_field("elapsed_us", want.elapsed, got.elapsed);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predicted_stats.push_back(advance_timing(i_s_tdata[fts_pkg::STAMP_W-1:0]));
            end
        end
        o_pending    <= predicted_stats.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 100;
    localparam int TICK_TARGET = 1000;

    typedef enum int {
        PAT_STEADY,
        PAT_JITTER,
        PAT_NOISE,
        PAT_FROZEN,
        PAT_TINY,
        PAT_WRAP
    } t_tick_pattern;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic                            cfg_wdata = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [fts_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [fts_pkg::OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int idle_cycles = 0;
    int ticks_sent = 0;
    logic quiet_phase = 1'b0;
    logic [fts_pkg::STAMP_W-1:0] stamp;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    frame_time_smoother_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    frame_time_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Quiet phases run back to back; otherwise each request first waits a randomly drawn gap.
    function automatic int draw_gap();
        return quiet_phase ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic logic [fts_pkg::STAMP_W-1:0] random_stamp();
        return fts_pkg::STAMP_W'({$urandom(), $urandom()});
    endfunction

    // Presents one tick and returns at the edge where it is taken.
    task automatic send_tick(input logic [fts_pkg::STAMP_W-1:0] now);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= now;
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
    endtask

    // Stops sending and waits until every predicted result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic write_paused(input logic value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: a random stall before each request, then wait for it.
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Ends the run when nothing moves on either stream for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_tick_pattern pattern;
        int            run_len;
        int            sel;
        logic          pause_phase;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks: first tick from zero, nominal frames, zero delta,
        // the clamp boundary, huge and backward jumps, and the stamp wrap.
        send_tick(48'd0);
        send_tick(48'd16666);
        send_tick(48'd33333);
        send_tick(48'd33333);
        send_tick(48'd133333);
        send_tick(48'd233334);
        send_tick(48'h7FFF_FFFF_FFFF);
        send_tick(48'h7FFF_FFFF_FFF0);
        send_tick(48'hFFFF_FFFF_FF00);
        send_tick(48'hFFFF_FFFF_FFFF);
        send_tick(48'd0);
        send_tick(48'd1);
        send_tick(48'd100);

        // Paused ticks leave the timing state untouched.
        write_paused(1'b1);
        send_tick(48'hAAAA_AAAA_AAAA);
        send_tick(48'h5555_5555_5555);
        send_tick(48'hFFFF_FFFF_FFFF);
        send_tick(48'd0);
        write_paused(1'b0);
        send_tick(48'h5555_5555_5555);
        send_tick(48'hAAAA_AAAA_AAAA);
        send_tick(48'hAAAA_AAAA_AAAA + 48'd16667);
        stamp = 48'hAAAA_AAAA_AAAA + 48'd33334;
        send_tick(stamp);

        // Random phases, mostly plausible frame streams with random content.
        while (ticks_sent < TICK_TARGET) begin
            pause_phase = ($urandom_range(0, 5) == 0);
            write_paused(pause_phase);
            quiet_phase = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel <= 3) begin
                pattern = PAT_STEADY;
            end else if (sel <= 5) begin
                pattern = PAT_JITTER;
            end else if (sel == 6) begin
                pattern = PAT_NOISE;
            end else if (sel == 7) begin
                pattern = PAT_FROZEN;
            end else if (sel == 8) begin
                pattern = PAT_TINY;
            end else begin
                pattern = PAT_WRAP;
            end
            if (pause_phase) begin
                run_len = $urandom_range(3, 12);
            end else if (pattern == PAT_FROZEN) begin
                // Long enough to flush the whole window with zero deltas.
                run_len = $urandom_range(66, 80);
            end else begin
                run_len = $urandom_range(10, 60);
            end
            if (pattern == PAT_WRAP) begin
                stamp = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 500000));
            end
            for (int k = 0; k < run_len; k++) begin
                case (pattern)
                    PAT_STEADY: begin
                        stamp = stamp + 48'($urandom_range(16000, 17500));
                    end
                    PAT_JITTER: begin
                        stamp = stamp + 48'($urandom_range(0, 120000));
                    end
                    PAT_NOISE: begin
                        stamp = random_stamp();
                    end
                    PAT_FROZEN: begin
                        stamp = stamp;
                    end
                    PAT_TINY: begin
                        stamp = stamp + 48'($urandom_range(0, 70));
                    end
                    default: begin
                        stamp = stamp + 48'($urandom_range(0, 30000));
                    end
                endcase
                send_tick(stamp);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
